>>> rtl/core/uer_pkg.sv
// Shared types and constants for the ultrasonic echo ranger.
package uer_pkg;

  typedef enum logic [2:0] {
    PH_IDLE      = 3'd0,
    PH_TRIG_LOW  = 3'd1,
    PH_TRIG_HIGH = 3'd2,
    PH_WAIT_LOW  = 3'd3,
    PH_WAIT_HIGH = 3'd4,
    PH_MEASURE   = 3'd5
  } phase_t;

  localparam logic [1:0] REG_MAX_DIST = 2'd0;
  localparam logic [1:0] REG_TIMEOUT  = 2'd1;

  localparam logic [16:0] MAX_DIST_RESET = 17'd40000;
  localparam logic [23:0] TIMEOUT_RESET  = 24'd1000000;

  localparam logic [23:0] LOW_TICKS  = 24'd2;
  localparam logic [23:0] HIGH_TICKS = 24'd10;

  localparam logic signed [19:0] SPEED_BASE  = 20'sd331300;
  localparam logic signed [19:0] SPEED_SLOPE = 20'sd606;
  localparam logic [18:0]        SPEED_DIV   = 19'd200000;
  localparam logic [18:0]        SPEED_DIV2  = 19'd400000;

  typedef struct packed {
    logic latch;
    logic cnt_set1;
    logic cnt_clear;
    logic cnt_inc;
    logic acc_init;
    logic acc_add;
    logic trig_on;
    logic busy;
    logic meas_done;
    logic tmo;
  } cmd_t;

  typedef struct packed {
    logic ge_low;
    logic ge_high;
    logic timeout_hit;
  } sts_t;

endpackage

>>> rtl/core/uer_ctrl.sv
// Phase controller of the echo ranger: sequences trigger, wait and measure.
module uer_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          step,
  input  logic          start_req,
  input  logic          echo_level,
  input  uer_pkg::sts_t sts,
  output uer_pkg::cmd_t cmd
);

  uer_pkg::phase_t phase;
  uer_pkg::phase_t phase_next;
  logic            done;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= uer_pkg::PH_IDLE;
    end else if (step) begin
      phase <= phase_next;
    end
  end

  always_comb begin
    phase_next = phase;
    cmd        = '0;
    done       = 1'b0;
    unique case (phase)
      uer_pkg::PH_IDLE: begin
        if (start_req) begin
          phase_next   = uer_pkg::PH_TRIG_LOW;
          cmd.latch    = 1'b1;
          cmd.cnt_set1 = 1'b1;
        end
      end
      uer_pkg::PH_TRIG_LOW: begin
        if (sts.ge_low) begin
          phase_next   = uer_pkg::PH_TRIG_HIGH;
          cmd.cnt_set1 = 1'b1;
        end else begin
          cmd.cnt_inc = 1'b1;
        end
      end
      uer_pkg::PH_TRIG_HIGH: begin
        if (sts.ge_high) begin
          phase_next    = uer_pkg::PH_WAIT_LOW;
          cmd.cnt_clear = 1'b1;
        end else begin
          cmd.cnt_inc = 1'b1;
        end
      end
      uer_pkg::PH_WAIT_LOW, uer_pkg::PH_WAIT_HIGH, uer_pkg::PH_MEASURE: begin
        cmd.cnt_inc = 1'b1;
        if (phase == uer_pkg::PH_WAIT_LOW) begin
          if (!echo_level) phase_next = uer_pkg::PH_WAIT_HIGH;
        end else if (phase == uer_pkg::PH_WAIT_HIGH) begin
          if (echo_level) begin
            phase_next   = uer_pkg::PH_MEASURE;
            cmd.acc_init = 1'b1;
          end
        end else begin
          if (echo_level) begin
            cmd.acc_add = 1'b1;
          end else begin
            cmd.meas_done = 1'b1;
            done          = 1'b1;
          end
        end
        if (!done && sts.timeout_hit) begin
          cmd.tmo = 1'b1;
          done    = 1'b1;
        end
        if (done) phase_next = uer_pkg::PH_IDLE;
      end
      default: begin
        phase_next = uer_pkg::PH_IDLE;
      end
    endcase
    cmd.trig_on = (phase_next == uer_pkg::PH_TRIG_HIGH);
    cmd.busy    = (phase_next != uer_pkg::PH_IDLE);
  end

endmodule

>>> rtl/core/uer_dp.sv
// Datapath of the echo ranger: counters, distance accumulator and result register.
module uer_dp #(
  parameter int SENSOR_COUNT = 4
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    step,
  input  uer_pkg::cmd_t           cmd,
  output uer_pkg::sts_t           sts,
  input  logic                    cfg_we,
  input  logic [1:0]              cfg_index,
  input  logic [23:0]             cfg_data,
  input  logic [1:0]              sensor_index,
  input  logic signed [7:0]       temperature_c,
  output logic [SENSOR_COUNT-1:0] trigger_lines,
  output logic                    busy_res,
  output logic                    done_res,
  output logic [16:0]             distance_hundredths,
  output logic                    out_of_range,
  output logic                    timed_out
);

  logic [16:0] max_dist;
  logic [23:0] timeout;
  logic [23:0] tick_count;
  logic [23:0] tick_inc;
  logic [1:0]  latched_sensor;
  logic [1:0]  mult_q;
  logic [17:0] mult_r;
  logic [25:0] acc_q;
  logic [17:0] acc_r;

  logic signed [19:0] mult_s;
  logic [18:0]        mult_u;
  logic [1:0]         mult_q_next;
  logic [17:0]        mult_r_next;
  logic [18:0]        sum_r;
  logic               carry;
  logic               over;
  logic [SENSOR_COUNT-1:0] trig_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_dist <= uer_pkg::MAX_DIST_RESET;
      timeout  <= uer_pkg::TIMEOUT_RESET;
    end else if (cfg_we) begin
      if (cfg_index == uer_pkg::REG_MAX_DIST) max_dist <= cfg_data[16:0];
      if (cfg_index == uer_pkg::REG_TIMEOUT)  timeout  <= cfg_data;
    end
  end

  assign tick_inc        = tick_count + 24'd1;
  assign sts.ge_low      = (tick_count >= uer_pkg::LOW_TICKS);
  assign sts.ge_high     = (tick_count >= uer_pkg::HIGH_TICKS);
  assign sts.timeout_hit = (tick_inc >= timeout);

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count <= '0;
    end else if (step) begin
      priority if (cmd.cnt_set1) begin
        tick_count <= 24'd1;
      end else if (cmd.cnt_clear) begin
        tick_count <= '0;
      end else if (cmd.cnt_inc) begin
        tick_count <= tick_inc;
      end
    end
  end

  always_comb begin
    mult_s = 20'(temperature_c) * uer_pkg::SPEED_SLOPE + uer_pkg::SPEED_BASE;
    mult_u = mult_s[18:0];
    if (mult_u >= uer_pkg::SPEED_DIV2) begin
      mult_q_next = 2'd2;
      mult_r_next = 18'(mult_u - uer_pkg::SPEED_DIV2);
    end else begin
      mult_q_next = 2'd1;
      mult_r_next = 18'(mult_u - uer_pkg::SPEED_DIV);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      latched_sensor <= '0;
    end else if (step && cmd.latch) begin
      latched_sensor <= sensor_index;
    end
  end

  always_ff @(posedge clk) begin
    if (step && cmd.latch) begin
      mult_q <= mult_q_next;
      mult_r <= mult_r_next;
    end
  end

  // Running quotient and remainder of width * speed / divisor
  always_comb begin
    sum_r = {1'b0, acc_r} + {1'b0, mult_r};
    carry = (sum_r >= uer_pkg::SPEED_DIV);
  end

  always_ff @(posedge clk) begin
    if (step) begin
      if (cmd.acc_init) begin
        acc_q <= 26'(mult_q);
        acc_r <= mult_r;
      end else if (cmd.acc_add) begin
        acc_q <= acc_q + 26'(mult_q) + 26'(carry);
        acc_r <= carry ? 18'(sum_r - uer_pkg::SPEED_DIV) : sum_r[17:0];
      end
    end
  end

  assign over = (acc_q > 26'(max_dist));

  always_comb begin
    for (int s = 0; s < SENSOR_COUNT; s++) begin
      trig_next[s] = cmd.trig_on && (int'(latched_sensor) == s);
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      trigger_lines       <= trig_next;
      busy_res            <= cmd.busy;
      done_res            <= cmd.meas_done || cmd.tmo;
      distance_hundredths <= (cmd.meas_done && !over) ? acc_q[16:0] : 17'd0;
      out_of_range        <= cmd.meas_done && over;
      timed_out           <= cmd.tmo;
    end
  end

endmodule

>>> rtl/core/ultrasonic_echo_ranger.sv
// Top level of the ultrasonic echo ranger.
//
// Each input beat is one microsecond tick: start_req, sensor_index,
// temperature_c and the sampled echo_level. Every input beat yields exactly
// one output beat with the trigger lines, busy and done flags, and on done
// the distance in hundredths of a centimetre with out_of_range / timed_out.
// A start in idle drives the chosen trigger low for 2 ticks, high for 10,
// then waits for a fresh echo pulse and counts its width, bounded by
// the timeout register. The distance is accumulated one speed step per echo
// tick, so no wide multiply or divide sits in any path.
// Each output beat is registered in the cycle after its input; the rate is
// one beat per cycle while out_ready holds, set by the single output register.
// in_ready is high while the output register is empty or being taken, so a
// stalled receiver holds the input side after one beat.
// Reset returns to idle and loads the register defaults (40000, 1000000).
// Writes through cfg_we/cfg_index/cfg_data are registered and accepted mid-run.
module ultrasonic_echo_ranger #(
  parameter int SENSOR_COUNT = 4
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_we,
  input  logic [1:0]              cfg_index,
  input  logic [23:0]             cfg_data,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    start_req,
  input  logic [1:0]              sensor_index,
  input  logic signed [7:0]       temperature_c,
  input  logic                    echo_level,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [SENSOR_COUNT-1:0] trigger_lines,
  output logic                    busy_res,
  output logic                    done_res,
  output logic [16:0]             distance_hundredths,
  output logic                    out_of_range,
  output logic                    timed_out
);

  uer_pkg::cmd_t cmd;
  uer_pkg::sts_t sts;
  logic          step;

  assign in_ready = !out_valid || out_ready;
  assign step     = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  uer_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .step       (step),
    .start_req  (start_req),
    .echo_level (echo_level),
    .sts        (sts),
    .cmd        (cmd)
  );

  uer_dp #(
    .SENSOR_COUNT (SENSOR_COUNT)
  ) u_dp (
    .clk                 (clk),
    .rst                 (rst),
    .step                (step),
    .cmd                 (cmd),
    .sts                 (sts),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .sensor_index        (sensor_index),
    .temperature_c       (temperature_c),
    .trigger_lines       (trigger_lines),
    .busy_res            (busy_res),
    .done_res            (done_res),
    .distance_hundredths (distance_hundredths),
    .out_of_range        (out_of_range),
    .timed_out           (timed_out)
  );

endmodule

>>> sim/tb_ultrasonic_echo_ranger.sv
// Self-checking testbench for the ultrasonic echo ranger: directed ranging cases, then random ticks.
module tb_ultrasonic_echo_ranger;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] REG_SPARE_2 = 2'd2;
  localparam logic [1:0] REG_SPARE_3 = 2'd3;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int RANDOM_TICKS = 180;

  typedef struct packed {
    logic [3:0]  trig;
    logic        busy;
    logic        done;
    logic [16:0] hundredths;
    logic        oor;
    logic        tmo;
  } ranging_beat_t;

  logic               clk;
  logic               rst;
  logic               cfg_we;
  logic [1:0]         cfg_index;
  logic [23:0]        cfg_data;
  logic               in_valid;
  logic               in_ready;
  logic               start_req;
  logic [1:0]         sensor_index;
  logic signed [7:0]  temperature_c;
  logic               echo_level;
  logic               out_valid;
  logic               out_ready;
  logic [3:0]         trigger_lines;
  logic               busy_res;
  logic               done_res;
  logic [16:0]        distance_hundredths;
  logic               out_of_range;
  logic               timed_out;

  uer_pkg::phase_t   ranger_phase = uer_pkg::PH_IDLE;
  logic [23:0]       ranger_ticks = '0;
  logic [23:0]       ranger_width = '0;
  logic [1:0]        ranger_sensor = '0;
  logic signed [7:0] ranger_temp = '0;
  logic [16:0]       max_dist_setting = uer_pkg::MAX_DIST_RESET;
  logic [23:0]       timeout_setting = uer_pkg::TIMEOUT_RESET;

  ranging_beat_t pending_ranging[$];

  int errors = 0;
  int ticks_sent = 0;
  int ranges_measured = 0;
  int timeouts_seen = 0;
  int out_of_range_seen = 0;
  int cycle_count = 0;
  int src_idle_pct = 0;
  int snk_stall_pct = 0;

  ultrasonic_echo_ranger dut (
    .clk                 (clk),
    .rst                 (rst),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .start_req           (start_req),
    .sensor_index        (sensor_index),
    .temperature_c       (temperature_c),
    .echo_level          (echo_level),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .trigger_lines       (trigger_lines),
    .busy_res            (busy_res),
    .done_res            (done_res),
    .distance_hundredths (distance_hundredths),
    .out_of_range        (out_of_range),
    .timed_out           (timed_out)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  function automatic ranging_beat_t step_ranger(input logic start, input logic [1:0] idx,
                                                input logic signed [7:0] temp,
                                                input logic echo);
    ranging_beat_t r;
    logic          fin;
    logic [63:0]   d;
    int            speed;
    r = '0;
    fin = 1'b0;
    d = '0;
    case (ranger_phase)
      uer_pkg::PH_IDLE: begin
        if (start) begin
          ranger_sensor = idx;
          ranger_temp = temp;
          ranger_phase = uer_pkg::PH_TRIG_LOW;
          ranger_ticks = 24'd1;
          ranger_width = '0;
        end
      end
      uer_pkg::PH_TRIG_LOW: begin
        if (ranger_ticks >= uer_pkg::LOW_TICKS) begin
          ranger_phase = uer_pkg::PH_TRIG_HIGH;
          ranger_ticks = 24'd1;
        end else begin
          ranger_ticks = ranger_ticks + 24'd1;
        end
      end
      uer_pkg::PH_TRIG_HIGH: begin
        if (ranger_ticks >= uer_pkg::HIGH_TICKS) begin
          ranger_phase = uer_pkg::PH_WAIT_LOW;
          ranger_ticks = '0;
        end else begin
          ranger_ticks = ranger_ticks + 24'd1;
        end
      end
      default: begin
        ranger_ticks = ranger_ticks + 24'd1;
        if (ranger_phase == uer_pkg::PH_WAIT_LOW) begin
          if (!echo) ranger_phase = uer_pkg::PH_WAIT_HIGH;
        end else if (ranger_phase == uer_pkg::PH_WAIT_HIGH) begin
          if (echo) begin
            ranger_phase = uer_pkg::PH_MEASURE;
            ranger_width = 24'd1;
          end
        end else if (echo) begin
          ranger_width = ranger_width + 24'd1;
        end else begin
          fin = 1'b1;
          speed = int'(uer_pkg::SPEED_BASE) + int'(uer_pkg::SPEED_SLOPE) * int'(ranger_temp);
          d = (64'(ranger_width) * 64'(speed)) / 64'(uer_pkg::SPEED_DIV);
          if (d > 64'(max_dist_setting)) begin
            d = '0;
            r.oor = 1'b1;
          end
        end
        if (!fin && ranger_ticks >= timeout_setting) begin
          fin = 1'b1;
          r.tmo = 1'b1;
          ranger_width = '0;
          d = '0;
        end
        if (fin) ranger_phase = uer_pkg::PH_IDLE;
      end
    endcase
    r.done = fin;
    r.hundredths = d[16:0];
    r.busy = (ranger_phase != uer_pkg::PH_IDLE);
    if (ranger_phase == uer_pkg::PH_TRIG_HIGH) r.trig = 4'b0001 << ranger_sensor;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin : scoreboard
    ranging_beat_t want;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (pending_ranging.size() == 0) begin
          $display("%0t: result beat with nothing expected", $time);
          errors++;
        end else begin
          want = pending_ranging.pop_front();
          check_field("trigger_lines", 32'(want.trig), 32'(trigger_lines));
          check_field("busy_res", 32'(want.busy), 32'(busy_res));
          check_field("done_res", 32'(want.done), 32'(done_res));
          check_field("distance_hundredths", 32'(want.hundredths), 32'(distance_hundredths));
          check_field("out_of_range", 32'(want.oor), 32'(out_of_range));
          check_field("timed_out", 32'(want.tmo), 32'(timed_out));
          if (want.done && !want.tmo && !want.oor) ranges_measured++;
          if (want.tmo) timeouts_seen++;
          if (want.oor) out_of_range_seen++;
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          uer_pkg::REG_MAX_DIST: max_dist_setting = cfg_data[16:0];
          uer_pkg::REG_TIMEOUT:  timeout_setting = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready)
        pending_ranging.push_back(step_ranger(start_req, sensor_index, temperature_c,
                                              echo_level));
    end
  end

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= snk_stall_pct);
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles", cycle_count);
      $display("ultrasonic_echo_ranger verification failed");
      $finish;
    end
  end

  function automatic logic signed [7:0] pick_temperature();
    if ($urandom_range(3) == 0) return 8'($urandom_range(255));
    return 8'($urandom_range(125) - 40);
  endfunction

  task automatic send_tick(input logic s, input logic [1:0] idx,
                           input logic signed [7:0] temp, input logic e);
    @(negedge clk);
    while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    start_req <= s;
    sensor_index <= idx;
    temperature_c <= temp;
    echo_level <= e;
    do @(posedge clk); while (!in_ready);
    ticks_sent++;
  endtask

  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_ranging.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [23:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic run_measurement(input logic [1:0] idx, input logic signed [7:0] temp,
                                 input int lead_high, input int low_gap, input int width,
                                 input int tail, input bit restart);
    send_tick(1'b1, idx, temp, 1'($urandom_range(1)));
    repeat (11)
      send_tick(restart | 1'($urandom_range(1)), 2'($urandom_range(3)),
                8'($urandom_range(255)), 1'($urandom_range(1)));
    repeat (lead_high) send_tick(1'b0, 2'($urandom_range(3)), pick_temperature(), 1'b1);
    repeat (low_gap) send_tick(1'b0, 2'($urandom_range(3)), pick_temperature(), 1'b0);
    repeat (width) send_tick(1'b0, 2'($urandom_range(3)), pick_temperature(), 1'b1);
    send_tick(1'b0, 2'($urandom_range(3)), pick_temperature(), 1'b0);
    repeat (tail)
      send_tick(1'b0, 2'($urandom_range(3)), pick_temperature(), 1'($urandom_range(1)));
  endtask

  task automatic test_default_registers();
    run_measurement(2'd0, 8'sd20, 0, 1, 3, 1, 1'b0);
  endtask

  task automatic test_timeout_zero();
    settle();
    write_reg(uer_pkg::REG_TIMEOUT, 24'd0);
    write_reg(uer_pkg::REG_MAX_DIST, 24'd100000);
    run_measurement(2'd3, -8'sd128, 0, 1, 2, 0, 1'b0);
  endtask

  task automatic test_out_of_range();
    settle();
    write_reg(uer_pkg::REG_TIMEOUT, 24'd1000);
    write_reg(uer_pkg::REG_MAX_DIST, 24'd0);
    run_measurement(2'd1, 8'sd85, 0, 1, 1, 0, 1'b0);
  endtask

  task automatic test_echo_high_at_wait();
    settle();
    write_reg(uer_pkg::REG_MAX_DIST, 24'd100000);
    run_measurement(2'd2, 8'sd127, 3, 2, 5, 1, 1'b0);
  endtask

  // echo falls on the tick just before the timeout is reached
  task automatic test_pulse_end_at_timeout();
    settle();
    write_reg(uer_pkg::REG_TIMEOUT, 24'd10);
    run_measurement(2'd1, -8'sd40, 0, 1, 8, 1, 1'b0);
  endtask

  task automatic test_start_while_busy();
    settle();
    write_reg(uer_pkg::REG_TIMEOUT, 24'd200);
    run_measurement(2'd3, 8'sd0, 0, 1, 6, 0, 1'b1);
  endtask

  task automatic test_config_mid_measurement();
    settle();
    write_reg(uer_pkg::REG_TIMEOUT, 24'hFFFFFF);
    send_tick(1'b1, 2'd3, 8'sd25, 1'b0);
    repeat (14) send_tick(1'b0, 2'd0, 8'sd0, 1'b0);
    settle();
    write_reg(uer_pkg::REG_TIMEOUT, 24'd5);
    repeat (3) send_tick(1'b0, 2'd0, 8'sd0, 1'b0);
  endtask

  task automatic test_unused_register_index();
    settle();
    write_reg(REG_SPARE_2, 24'hFFFFFF);
    write_reg(REG_SPARE_3, 24'd0);
    write_reg(uer_pkg::REG_MAX_DIST, 24'hFC0032);
    run_measurement(2'd0, 8'sd85, 0, 1, 30, 0, 1'b0);
    run_measurement(2'd1, 8'sd85, 0, 1, 20, 0, 1'b0);
  endtask

  task automatic test_long_echo();
    settle();
    write_reg(uer_pkg::REG_TIMEOUT, 24'hFFFFFF);
    write_reg(uer_pkg::REG_MAX_DIST, 24'd100000);
    run_measurement(2'd0, 8'sd85, 0, 1, 200, 1, 1'b0);
  endtask

  task automatic test_random_ranging(input int src_pct, input int snk_pct);
    int phase_end;
    int lim;
    src_idle_pct = src_pct;
    snk_stall_pct = snk_pct;
    repeat (2) begin
      settle();
      case ($urandom_range(3))
        0: lim = 0;
        1: lim = $urandom_range(200);
        2: lim = $urandom_range(100000);
        default: lim = 100000;
      endcase
      write_reg(uer_pkg::REG_MAX_DIST, 24'(lim));
      case ($urandom_range(7))
        0: write_reg(uer_pkg::REG_TIMEOUT, 24'($urandom_range(1)));
        1, 2, 3: write_reg(uer_pkg::REG_TIMEOUT, 24'($urandom_range(80, 20)));
        4, 5, 6: write_reg(uer_pkg::REG_TIMEOUT, 24'($urandom_range(200, 60)));
        default: write_reg(uer_pkg::REG_TIMEOUT, 24'hFFFFFF);
      endcase
      phase_end = ticks_sent + RANDOM_TICKS / 2;
      while (ticks_sent < phase_end) begin
        case ($urandom_range(9))
          0: begin
            repeat ($urandom_range(8, 1))
              send_tick(1'($urandom_range(1)), 2'($urandom_range(3)),
                        8'($urandom_range(255)), 1'($urandom_range(1)));
          end
          1: begin
            send_tick(1'b1, 2'($urandom_range(3)), pick_temperature(), 1'($urandom_range(1)));
            repeat ($urandom_range(30, 1))
              send_tick(1'b0, 2'($urandom_range(3)), pick_temperature(),
                        1'($urandom_range(1)));
          end
          default: begin
            run_measurement(2'($urandom_range(3)), pick_temperature(),
                            ($urandom_range(3) == 0) ? $urandom_range(3, 1) : 0,
                            $urandom_range(4, 1), $urandom_range(40, 1),
                            $urandom_range(2), 1'b0);
          end
        endcase
      end
    end
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    start_req = 1'b0;
    sensor_index = '0;
    temperature_c = '0;
    echo_level = 1'b0;
    out_ready = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_default_registers();
    test_timeout_zero();
    test_out_of_range();
    test_echo_high_at_wait();
    test_pulse_end_at_timeout();
    test_start_while_busy();
    test_config_mid_measurement();
    test_unused_register_index();
    test_long_echo();

    test_random_ranging(0, 0);
    test_random_ranging(85, 0);
    test_random_ranging(0, 85);
    test_random_ranging(11, 11);

    settle();
    repeat (16) @(posedge clk);
    if (pending_ranging.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, pending_ranging.size());
      errors++;
    end
    $display("Drove %0d ticks under four idle/stall mixes and several register settings.",
             ticks_sent);
    $display("Saw %0d valid ranges, %0d echo timeouts and %0d out-of-range results.",
             ranges_measured, timeouts_seen, out_of_range_seen);
    if (errors == 0) begin
      $display("ultrasonic_echo_ranger verification clean");
    end else begin
      $display("ultrasonic_echo_ranger verification failed");
    end
    $finish;
  end

endmodule
